/* hw/rtl/bblri_pkg.sv */
package bblri_pkg;

  localparam int unsigned ACC_W = 34;
  localparam logic [31:0] MAX_BYTES_RST = 32'd1048576;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_GET  = 1'b1;

  typedef struct packed {
    logic        opcode;
    logic [63:0] log_id;
    logic [23:0] entry_length;
  } in_word_t;

  typedef struct packed {
    logic        ok;
    logic [9:0]  slot;
    logic [10:0] entries_held;
    logic [31:0] bytes_held;
  } out_word_t;

endpackage

/* hw/rtl/bblri_len_mem.sv */
module bblri_len_mem #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned LEN_BITS = 24,
  localparam int unsigned IDX_W   = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  logic [LEN_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output logic [LEN_BITS-1:0] rdata_o
);

  logic [LEN_BITS-1:0] mem_q [DEPTH];
  logic [LEN_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bblri_acc_unit.sv */
module bblri_acc_unit #(
  parameter int unsigned LEN_BITS = 24
) (
  input  logic [bblri_pkg::ACC_W-1:0] a_i,
  input  logic [LEN_BITS-1:0]         b_i,
  input  logic                        sub_i,
  input  logic [31:0]                 limit_i,
  output logic [bblri_pkg::ACC_W-1:0] sum_o,
  output logic                        over_o
);

  import bblri_pkg::*;

  logic [ACC_W-1:0] b_ext;

  assign b_ext  = ACC_W'(b_i);
  assign sum_o  = sub_i ? (a_i - b_ext) : (a_i + b_ext);
  assign over_o = sum_o > ACC_W'(limit_i);

endmodule

/* hw/rtl/byte_budget_log_ring_index.sv */
// Index of a ring of DEPTH log entries kept under a byte budget (max_bytes, written
// through cfg_we_i / cfg_wdata_i, reset 1048576). A push (opcode 0) evicts the oldest
// entries until the new length fits or none is left, stores it at the next slot and
// records its id; a get (opcode 1) hits when the id lies in the window of held ids
// ending at the last pushed id and returns its slot. Only one word is in flight; a
// push walks the tail in S_EVICT, one evicted entry per step, paced by the single
// read port of the length memory and the one shared 34-bit add/subtract unit. Results
// sit in an output register, so a new word is taken while the last result still
// waits. Lengths outside the held window are never used, so the length memory needs
// no clearing after reset and the block is ready at once.
module byte_budget_log_ring_index #(
  parameter int unsigned DEPTH    = 1024,
  parameter int unsigned LEN_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  bblri_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output bblri_pkg::out_word_t out_word_o,
  input  logic                 cfg_we_i,
  input  logic [31:0]          cfg_wdata_i
);

  import bblri_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned XW    = IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_GET   = 5'b00010,
    S_PCHK  = 5'b00100,
    S_EVICT = 5'b01000,
    S_HOLD  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]    held_q, held_d;
  logic [IDX_W-1:0]    next_q, next_d;
  logic [IDX_W-1:0]    tail_q, tail_d;
  logic [31:0]         bytes_q, bytes_d;
  logic [63:0]         last_id_q, last_id_d;
  logic [31:0]         max_q;
  logic [ACC_W-1:0]    acc_q, acc_d;
  logic [LEN_BITS-1:0] len_q;
  logic [63:0]         id_q;
  logic [64:0]         diff_q;
  out_word_t           res_q, res;
  logic                out_valid_q;
  out_word_t           out_q;

  logic                in_acc;
  logic                out_free;
  logic                fin;
  logic                out_load;
  logic [LEN_BITS-1:0] len_in;
  logic [IDX_W-1:0]    next_inc;
  logic [IDX_W-1:0]    tail_inc;
  logic                full;

  logic                mem_we;
  logic [IDX_W-1:0]    raddr;
  logic [LEN_BITS-1:0] rdata;

  logic [ACC_W-1:0]    unit_a;
  logic [LEN_BITS-1:0] unit_b;
  logic                unit_sub;
  logic [ACC_W-1:0]    unit_sum;
  logic                unit_over;

  logic                hit;
  logic [IDX_W-1:0]    d_lo;
  logic [XW-1:0]       gx;
  logic [IDX_W-1:0]    get_slot;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign len_in   = LEN_BITS'({8'b0, in_word_i.entry_length});
  assign next_inc = (next_q == IDX_W'(DEPTH - 1)) ? '0 : next_q + 1'b1;
  assign tail_inc = (tail_q == IDX_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign full     = (held_q == CNT_W'(DEPTH));

  // window lookup from the difference taken at accept
  assign d_lo     = diff_q[IDX_W-1:0];
  assign hit      = !diff_q[64] && (diff_q[63:IDX_W] == '0) && (CNT_W'(d_lo) < held_q);
  assign gx       = XW'(next_q) + XW'(DEPTH - 1) - XW'(d_lo);
  assign get_slot = (gx >= XW'(DEPTH)) ? IDX_W'(gx - XW'(DEPTH)) : IDX_W'(gx);

  bblri_len_mem #(
    .DEPTH   (DEPTH),
    .LEN_BITS(LEN_BITS)
  ) u_len_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(next_q),
    .wdata_i(len_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  bblri_acc_unit #(
    .LEN_BITS(LEN_BITS)
  ) u_acc_unit (
    .a_i    (unit_a),
    .b_i    (unit_b),
    .sub_i  (unit_sub),
    .limit_i(max_q),
    .sum_o  (unit_sum),
    .over_o (unit_over)
  );

  always_comb begin
    unique case (state_q)
      S_IDLE: begin
        unit_a   = ACC_W'(bytes_q);
        unit_b   = len_in;
        unit_sub = 1'b0;
      end
      S_PCHK: begin
        unit_a   = acc_q;
        unit_b   = full ? rdata : '0;
        unit_sub = 1'b1;
      end
      default: begin
        unit_a   = acc_q;
        unit_b   = rdata;
        unit_sub = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    next_d    = next_q;
    tail_d    = tail_q;
    bytes_d   = bytes_q;
    last_id_d = last_id_q;
    acc_d     = acc_q;
    raddr     = next_q;
    mem_we    = 1'b0;
    fin       = 1'b0;
    res       = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_word_i.opcode == OP_GET) begin
            state_d = S_GET;
          end else begin
            acc_d   = unit_sum;
            state_d = S_PCHK;
          end
        end
      end
      S_GET: begin
        fin              = 1'b1;
        res.ok           = hit;
        res.slot         = hit ? 10'(get_slot) : '0;
        res.entries_held = 11'(held_q);
        res.bytes_held   = bytes_q;
      end
      S_PCHK: begin
        raddr = tail_q;
        if (unit_over && held_q != '0) begin
          state_d = S_EVICT;
        end else begin
          mem_we    = 1'b1;
          bytes_d   = unit_sum[31:0];
          next_d    = next_inc;
          last_id_d = id_q;
          if (full) begin
            tail_d = tail_inc;
          end else begin
            held_d = held_q + 1'b1;
          end
          fin              = 1'b1;
          res.ok           = 1'b1;
          res.slot         = 10'(next_q);
          res.entries_held = 11'(held_d);
          res.bytes_held   = unit_sum[31:0];
        end
      end
      S_EVICT: begin
        raddr  = tail_inc;
        tail_d = tail_inc;
        if (!unit_over || held_q == CNT_W'(1)) begin
          // oldest entry leaves and the new one arrives, so the count stays
          mem_we           = 1'b1;
          bytes_d          = unit_sum[31:0];
          next_d           = next_inc;
          last_id_d        = id_q;
          fin              = 1'b1;
          res.ok           = 1'b1;
          res.slot         = 10'(next_q);
          res.entries_held = 11'(held_q);
          res.bytes_held   = unit_sum[31:0];
        end else begin
          held_d = held_q - 1'b1;
          acc_d  = unit_sum;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? S_IDLE : S_HOLD;
    end
  end

  assign out_load = out_free && (fin || state_q == S_HOLD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      next_q      <= '0;
      tail_q      <= '0;
      bytes_q     <= '0;
      last_id_q   <= '0;
      max_q       <= MAX_BYTES_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      next_q    <= next_d;
      tail_q    <= tail_d;
      bytes_q   <= bytes_d;
      last_id_q <= last_id_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      len_q  <= len_in;
      id_q   <= in_word_i.log_id;
      diff_q <= {1'b0, last_id_q} - {1'b0, in_word_i.log_id};
    end
    if (fin && !out_free) begin
      res_q <= res;
    end
    if (out_load) begin
      out_q <= (state_q == S_HOLD) ? res_q : res;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* hw/rtl/bblri_chk.sv */
module bblri_chk (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input bblri_pkg::out_word_t out_word_o
);

  import bblri_pkg::*;

  // one word in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("word accepted while previous word still busy");

  // a miss carries slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.ok) |-> (out_word_o.slot == 10'd0))
    else $error("miss with nonzero slot");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_word_o))
    else $error("result changed while stalled");

endmodule

bind byte_budget_log_ring_index bblri_chk u_bblri_chk (.*);

/* bench/byte_budget_log_ring_index_tb.sv */
`timescale 1ns / 1ps

module byte_budget_log_ring_index_tb;
  import bblri_pkg::*;

  localparam int unsigned RING_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_word_t    in_word_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_word_t   out_word_o;
  logic        cfg_we_i;
  logic [31:0] cfg_wdata_i;

  byte_budget_log_ring_index DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // shadow copy of the ring index
  logic [23:0] len_of_slot [RING_DEPTH];
  logic [9:0]  head_slot;
  logic [10:0] held_n;
  logic [31:0] held_sum;
  logic [63:0] newest_id;
  logic [31:0] budget;

  in_word_t    log_ops_q [$];
  out_word_t   pending_reports [$];
  int unsigned ops_queued;
  int unsigned reports_seen;
  int unsigned errors;
  int unsigned cycle_count;
  logic [63:0] gen_last_id;
  bit          calm;
  bit          word_taken;
  bit          word_live;
  int unsigned send_gap;
  int unsigned hold_left;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic out_word_t predict_ring_step(input in_word_t w);
    out_word_t   r;
    logic [63:0] sum;
    logic [63:0] id_gap;
    logic [9:0]  tail;
    int unsigned walked;
    int unsigned total;
    r = '0;
    if (w.opcode == OP_PUSH) begin
      r.ok = 1'b1;
      r.slot = head_slot;
      sum = {32'd0, held_sum};
      tail = head_slot - held_n[9:0];
      total = 32'(held_n);
      walked = 0;
      if (sum - len_of_slot[head_slot] + w.entry_length > {32'd0, budget}) begin
        // evict from the tail until the new entry fits or the ring is empty
        while (walked < total) begin
          sum = sum - len_of_slot[tail];
          len_of_slot[tail] = '0;
          held_n = held_n - 11'd1;
          walked++;
          tail = tail + 10'd1;
          if (sum + w.entry_length <= {32'd0, budget}) break;
        end
      end
      sum = sum - len_of_slot[head_slot] + w.entry_length;
      len_of_slot[head_slot] = w.entry_length;
      held_sum = sum[31:0];
      head_slot = head_slot + 10'd1;
      if (held_n < RING_DEPTH) held_n = held_n + 11'd1;
      newest_id = w.log_id;
    end else if (held_n != 0 && w.log_id <= newest_id &&
                 newest_id - w.log_id < {53'd0, held_n}) begin
      id_gap = newest_id - w.log_id;
      r.ok = 1'b1;
      r.slot = head_slot - id_gap[9:0] - 10'd1;
    end
    r.entries_held = held_n;
    r.bytes_held = held_sum;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
  endtask

  // driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i <= '0;
    end else begin
      if (word_taken) begin
        word_taken = 1'b0;
        word_live = 1'b0;
        send_gap = calm ? 0 : $urandom_range(0, 7);
      end
      if (!word_live) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (log_ops_q.size() != 0) begin
          in_word_i <= log_ops_q.pop_front();
          word_live = 1'b1;
        end
      end
      in_valid_i <= word_live;
    end
  end

  // monitor
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_reports.push_back(predict_ring_step(in_word_i));
        word_taken = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        reports_seen++;
        hold_left = calm ? 0 : $urandom_range(0, 7);
        if (pending_reports.size() == 0) begin
          flag_mismatch("unexpected word", 64'd0, 64'(out_word_o));
        end else begin
          want = pending_reports.pop_front();
          if (out_word_o.ok !== want.ok)
            flag_mismatch("ok", 64'(want.ok), 64'(out_word_o.ok));
          if (out_word_o.slot !== want.slot)
            flag_mismatch("slot", 64'(want.slot), 64'(out_word_o.slot));
          if (out_word_o.entries_held !== want.entries_held)
            flag_mismatch("entries_held", 64'(want.entries_held),
                          64'(out_word_o.entries_held));
          if (out_word_o.bytes_held !== want.bytes_held)
            flag_mismatch("bytes_held", 64'(want.bytes_held), 64'(out_word_o.bytes_held));
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_op(input logic op, input logic [63:0] id, input logic [23:0] len);
    in_word_t w;
    w.opcode = op;
    w.log_id = id;
    w.entry_length = len;
    log_ops_q.push_back(w);
    ops_queued++;
  endtask

  task automatic settle();
    while (reports_seen != ops_queued) @(negedge clk_i);
  endtask

  task automatic set_budget(input logic [31:0] cap);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    budget = cap;
  endtask

  task automatic run_phase(input logic [31:0] cap, input int unsigned n,
                           input int unsigned push_pct, input logic [23:0] len_top,
                           input bit quiet);
    logic [63:0] id;
    logic [23:0] len;
    int unsigned roll;
    set_budget(cap);
    calm = quiet;
    for (int unsigned i = 0; i < n; i++) begin
      len = ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, len_top));
      if ($urandom_range(0, 99) < push_pct) begin
        roll = $urandom_range(0, 19);
        if (roll == 0) id = {$urandom, $urandom};
        else if (roll == 1) id = 64'($urandom_range(0, 3));
        else id = gen_last_id + 64'd1;
        gen_last_id = id;
        queue_op(OP_PUSH, id, len);
      end else begin
        roll = $urandom_range(0, 9);
        if (roll == 0) id = {$urandom, $urandom};
        else if (roll == 1) id = gen_last_id + 64'd1 + 64'($urandom_range(0, 3));
        else id = gen_last_id - 64'($urandom_range(0, 1100));
        queue_op(OP_GET, id, len);
      end
    end
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    for (int i = 0; i < RING_DEPTH; i++) len_of_slot[i] = '0;
    head_slot = '0;
    held_n = '0;
    held_sum = '0;
    newest_id = '0;
    budget = MAX_BYTES_RST;
    ops_queued = 0;
    reports_seen = 0;
    errors = 0;
    gen_last_id = '0;
    calm = 1'b0;
    word_taken = 1'b0;
    word_live = 1'b0;
    send_gap = 0;
    hold_left = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // get on empty ring, extreme lengths and ids, ids out of order
    queue_op(OP_GET, 64'd0, 24'd0);
    queue_op(OP_PUSH, 64'd0, 24'd0);
    queue_op(OP_PUSH, 64'd1, 24'hFFFFFF);
    queue_op(OP_GET, 64'd1, 24'hFFFFFF);
    queue_op(OP_GET, 64'd0, 24'd0);
    queue_op(OP_GET, 64'd2, 24'd0);
    queue_op(OP_GET, '1, 24'd0);
    queue_op(OP_PUSH, '1, 24'd100);
    queue_op(OP_GET, '1, 24'd0);
    queue_op(OP_GET, 64'hFFFF_FFFF_FFFF_FFFD, 24'd0);
    queue_op(OP_GET, 64'hFFFF_FFFF_FFFF_FFFC, 24'd0);
    queue_op(OP_GET, 64'd0, 24'd0);
    queue_op(OP_PUSH, 64'd5, 24'd500);
    queue_op(OP_GET, 64'd4, 24'd0);
    queue_op(OP_GET, 64'd2, 24'd0);
    queue_op(OP_GET, 64'd1, 24'd0);
    // entry larger than the whole budget
    queue_op(OP_PUSH, 64'd6, 24'hFFFFFF);
    // window reaching below zero
    queue_op(OP_PUSH, 64'd0, 24'd1);
    queue_op(OP_GET, 64'd0, 24'd0);
    queue_op(OP_GET, '1, 24'd0);
    queue_op(OP_GET, 64'd6, 24'd0);
    settle();

    run_phase(32'hFFFF_FFFF, 1200, 90, 24'd255, 1'b0);
    run_phase(32'd0, 150, 60, 24'd4095, 1'b1);
    run_phase(32'd4096, 250, 70, 24'd1023, 1'b0);
    run_phase($urandom, 175, 60, 24'hFFFFFF, 1'b0);
    run_phase(MAX_BYTES_RST, 175, 60, 24'h3FFFF, 1'b0);

    repeat (20) @(negedge clk_i);
    if (pending_reports.size() != 0)
      flag_mismatch("results never seen", 64'(pending_reports.size()), 64'd0);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
